>>> sv/modular_exponentiation_assert.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define MEXP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define MEXP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/mexp_pkg.sv
// Shared types for the modular exponentiation controller and datapath.
`default_nettype none

package mexp_pkg;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ONE  = 2'd1,
    RES_ACC  = 2'd2
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     init;     // load base for reduction, r = 1, latch exponent
    logic     dbl;      // acc = 2*acc mod m
    logic     add;      // acc += x mod m when top multiplier bit set; shift y
    logic     keep_b;   // reduced base = acc
    logic     keep_r;   // r = acc
    logic     sq_go;    // start r*r
    logic     ml_go;    // start r*b
    logic     src_acc;  // operand for sq_go/ml_go comes from acc instead of r
    logic     shift_e;  // next exponent bit
    logic     emit;     // register a result item
    res_sel_t res_sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic base_zero;
    logic mod_small;
    logic exp_zero;
    logic ebit;
  } status_t;

endpackage

`default_nettype wire

>>> sv/modular_exponentiation.sv
// Base 0, modulus < 2 or exponent 0 are answered straight from idle, without running the sequence;
// otherwise the base is reduced, then each exponent bit takes a squaring plus a multiply when the bit is set.
// Every modular product runs bit-serially through one shared add/compare/subtract unit:
// a doubling step and a conditional add step per multiplier bit, then a closing step to hand the product on.
// One item at a time: start is taken again in the cycle the result strobe shows.
// Synchronous reset idles the sequencer and sets exponent to 3 and modulus to 33.
`default_nettype none
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter  int WIDTH  = 32,
  localparam int DATA_W = (WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = (WIDTH > 32) ? 4 : 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [WIDTH-1:0]  base,
  output logic                   done,
  output logic [WIDTH-1:0]       power_mod,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;
  logic             wr_en;
  logic             reg_sel;
  cmd_t             cmd;
  status_t          status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1];
  assign prdata  = reg_sel ? DATA_W'(modulus) : DATA_W'(exponent);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= WIDTH'(3);
      modulus  <= WIDTH'(33);
    end else if (wr_en) begin
      if (reg_sel) begin
        modulus <= pwdata[WIDTH-1:0];
      end else begin
        exponent <= pwdata[WIDTH-1:0];
      end
    end
  end

  mexp_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .base      (base),
    .exponent  (exponent),
    .modulus   (modulus),
    .status    (status),
    .done      (done),
    .power_mod (power_mod)
  );

  `MEXP_ASSERT_IMP(a_result_below_mod, done && (modulus >= WIDTH'(2)), power_mod < modulus)

endmodule

`default_nettype wire

>>> sv/mexp_dp.sv
// Datapath: operand registers, shared modular add unit and result register.
`default_nettype none
`include "modular_exponentiation_assert.svh"

module mexp_dp
  import mexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  input  wire logic [WIDTH-1:0] base,
  input  wire logic [WIDTH-1:0] exponent,
  input  wire logic [WIDTH-1:0] modulus,
  output status_t               status,
  output logic                  done,
  output logic [WIDTH-1:0]      power_mod
);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xop;
  logic [WIDTH-1:0] yop;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] bred;
  logic [WIDTH-1:0] esh;

  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;
  logic [WIDTH-1:0] sum_mod;
  logic [WIDTH-1:0] opnd;

  // both addends are below m, so one conditional subtract reduces the sum
  assign addend  = cmd.dbl ? acc : xop;
  assign sum     = {1'b0, acc} + {1'b0, addend};
  assign sum_red = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
  assign sum_mod = sum_red[WIDTH-1:0];
  assign opnd    = cmd.src_acc ? acc : r;

  assign status.base_zero = (base == '0);
  assign status.mod_small = (modulus < WIDTH'(2));
  assign status.exp_zero  = (exponent == '0);
  assign status.ebit      = esh[WIDTH-1];

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.sq_go || cmd.ml_go) begin
      acc <= '0;
    end else if (cmd.dbl || (cmd.add && yop[WIDTH-1])) begin
      acc <= sum_mod;
    end

    if (cmd.init) begin
      xop <= WIDTH'(1);
      yop <= base;
    end else if (cmd.sq_go) begin
      xop <= opnd;
      yop <= opnd;
    end else if (cmd.ml_go) begin
      xop <= opnd;
      yop <= bred;
    end else if (cmd.add) begin
      yop <= yop << 1;
    end

    if (cmd.init) begin
      r <= WIDTH'(1);
    end else if (cmd.keep_r) begin
      r <= acc;
    end

    if (cmd.keep_b) begin
      bred <= acc;
    end

    if (cmd.init) begin
      esh <= exponent;
    end else if (cmd.shift_e) begin
      esh <= esh << 1;
    end

    if (cmd.emit) begin
      case (cmd.res_sel)
        RES_ZERO: power_mod <= '0;
        RES_ONE:  power_mod <= WIDTH'(1);
        RES_ACC:  power_mod <= acc;
        default:  power_mod <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  `MEXP_ASSERT_IMP(a_operands_reduced, cmd.dbl || cmd.add, (acc < modulus) && (xop < modulus))

endmodule

`default_nettype wire

>>> sv/mexp_ctrl.sv
// Controller: sequences reduction, squarings and multiplications over the exponent bits.
`default_nettype none
`include "modular_exponentiation_assert.svh"

module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output logic         busy,
  output cmd_t         cmd
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_RED_D  = 10'b00_0000_0010,
    ST_RED_A  = 10'b00_0000_0100,
    ST_B_SET  = 10'b00_0000_1000,
    ST_SQ_D   = 10'b00_0001_0000,
    ST_SQ_A   = 10'b00_0010_0000,
    ST_SQ_END = 10'b00_0100_0000,
    ST_ML_D   = 10'b00_1000_0000,
    ST_ML_A   = 10'b01_0000_0000,
    ST_ML_END = 10'b10_0000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] ecnt;
  logic [CNT_W-1:0] ecnt_next;
  logic             special;

  assign special = status.mod_small || status.base_zero || status.exp_zero;
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ecnt_next  = ecnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (special) begin
            cmd.emit    = 1'b1;
            cmd.res_sel = (status.mod_small || status.base_zero) ? RES_ZERO : RES_ONE;
          end else begin
            cmd.init   = 1'b1;
            cnt_next   = '0;
            ecnt_next  = '0;
            state_next = ST_RED_D;
          end
        end
      end
      ST_RED_D: begin
        cmd.dbl    = 1'b1;
        state_next = ST_RED_A;
      end
      ST_RED_A: begin
        cmd.add = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_B_SET;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_RED_D;
        end
      end
      ST_B_SET: begin
        cmd.keep_b = 1'b1;
        cmd.sq_go  = 1'b1;
        state_next = ST_SQ_D;
      end
      ST_SQ_D: begin
        cmd.dbl    = 1'b1;
        state_next = ST_SQ_A;
      end
      ST_SQ_A: begin
        cmd.add = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_SQ_END;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_SQ_D;
        end
      end
      ST_SQ_END: begin
        cmd.keep_r  = 1'b1;
        cmd.src_acc = 1'b1;
        if (status.ebit) begin
          cmd.ml_go  = 1'b1;
          state_next = ST_ML_D;
        end else begin
          cmd.shift_e = 1'b1;
          if (ecnt == LAST) begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_ACC;
            state_next  = ST_IDLE;
          end else begin
            ecnt_next  = ecnt + 1'b1;
            cmd.sq_go  = 1'b1;
            state_next = ST_SQ_D;
          end
        end
      end
      ST_ML_D: begin
        cmd.dbl    = 1'b1;
        state_next = ST_ML_A;
      end
      ST_ML_A: begin
        cmd.add = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_ML_END;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_ML_D;
        end
      end
      ST_ML_END: begin
        cmd.keep_r  = 1'b1;
        cmd.src_acc = 1'b1;
        cmd.shift_e = 1'b1;
        if (ecnt == LAST) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_ACC;
          state_next  = ST_IDLE;
        end else begin
          ecnt_next  = ecnt + 1'b1;
          cmd.sq_go  = 1'b1;
          state_next = ST_SQ_D;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
    end
  end

  `MEXP_ASSERT_NXT(a_start_runs, start && !busy && !special, busy)
  `MEXP_ASSERT_NXT(a_emit_idles, cmd.emit, !busy)

endmodule

`default_nettype wire
